// ----- rtl/core/dhd_pkg.sv -----
package dhd_pkg;

	// Port field widths
	localparam int CMD_W   = 2;
	localparam int PT_W    = 24;
	localparam int CAP_W   = 23;
	localparam int CNT_W   = 20;

	// Defaults for the top-level parameters
	localparam int MAX_REF_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF     = 24;

	// Squared distances: three squares of 24-bit magnitudes fit in 50 bits
	localparam int SQ_W   = 50;
	localparam int ROOT_W = SQ_W / 2;

	// Query counter saturates here
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// distance_cap after reset: 100.0 in Q7.16
	localparam logic [CAP_W-1:0] CAP_RESET = 23'd6553600;

	// APB register map
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_DISTANCE_CAP = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Status from the distance pipeline to the controller
	typedef struct packed {
		logic busy;
		logic dist_valid;
	} pipe_stat_t;

endpackage

// ----- rtl/core/dhd_if.sv -----
// Request channel: command and point
interface dhd_req_if;
	logic                          valid;
	logic                          ready;
	logic [dhd_pkg::CMD_W-1:0]     cmd;
	logic signed [dhd_pkg::PT_W-1:0] point_x;
	logic signed [dhd_pkg::PT_W-1:0] point_y;
	logic signed [dhd_pkg::PT_W-1:0] point_z;

	modport source (output valid, cmd, point_x, point_y, point_z, input ready);
	modport sink   (input valid, cmd, point_x, point_y, point_z, output ready);
endinterface

// Result channel: report of the running distance
interface dhd_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dhd_pkg::CAP_W-1:0]  hausdorff_distance;
	logic [dhd_pkg::CNT_W-1:0]  query_count;
	logic                       store_overflowed;

	modport source (output valid, hausdorff_distance, query_count, store_overflowed,
		input ready);
	modport sink   (input valid, hausdorff_distance, query_count, store_overflowed,
		output ready);
endinterface

// ----- rtl/core/dhd_ref_mem.sv -----
// Reference point store: one write port, one registered read port
module dhd_ref_mem #(
	parameter int DEPTH = dhd_pkg::MAX_REF_POINTS_DEF,
	parameter int AW    = 10,
	parameter int WORD_W = 3 * dhd_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/dhd_dist_pipe.sv -----
// Squared distance pipeline: one stored point per cycle
// s1 memory data, s2 per-axis squares, s3 sum
module dhd_dist_pipe #(
	parameter int COORD_BITS = dhd_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        issue,
	input  logic [3*COORD_BITS-1:0]     ref_word,
	input  logic [COORD_BITS-1:0]       query_x,
	input  logic [COORD_BITS-1:0]       query_y,
	input  logic [COORD_BITS-1:0]       query_z,
	output dhd_pkg::pipe_stat_t         stat,
	output logic [dhd_pkg::SQ_W-1:0]    sq_dist
);

	localparam int CB   = COORD_BITS;
	localparam int SQ_P = 2 * CB + 2;

	logic            valid_s1, valid_s2, valid_s3;
	logic [SQ_P-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [SQ_P-1:0] sum_s3;

	// Square of the difference of two signed coordinates
	function automatic logic [SQ_P-1:0] sq_diff(input logic [CB-1:0] a,
			input logic [CB-1:0] b);
		logic signed [CB:0] d;
		logic [CB:0]        m;
		logic [SQ_P-1:0]    p;
		d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
		m = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
		p = SQ_P'(m) * SQ_P'(m);
		return p;
	endfunction

	// Valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		sqx_s2 <= sq_diff(query_x, ref_word[CB-1:0]);
		sqy_s2 <= sq_diff(query_y, ref_word[2*CB-1:CB]);
		sqz_s2 <= sq_diff(query_z, ref_word[3*CB-1:2*CB]);
		sum_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
	end

	assign sq_dist         = dhd_pkg::SQ_W'(sum_s3);
	assign stat.busy       = valid_s1 | valid_s2 | valid_s3;
	assign stat.dist_valid = valid_s3;

endmodule

// ----- rtl/core/dhd_isqrt.sv -----
// Integer square root, one result bit per cycle
module dhd_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dhd_pkg::SQ_W-1:0]    operand,
	output logic                        busy,
	output logic [dhd_pkg::ROOT_W-1:0]  root
);

	localparam int W = dhd_pkg::SQ_W;
	localparam logic [W-1:0] BIT_START = W'(1) << (W - 2);

	logic [W-1:0] v_q, res_q, bit_q;
	logic [W-1:0] trial;

	assign trial = res_q + bit_q;

	// Bit register doubles as the busy marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= BIT_START;
		end else begin
			bit_q <= bit_q >> 2;
		end
	end

	// Remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign busy = (bit_q != '0);
	assign root = res_q[dhd_pkg::ROOT_W-1:0];

endmodule

// ----- rtl/core/directed_hausdorff_distance_unit.sv -----
// Directed Hausdorff distance unit.
// Requests arrive on req (valid/ready): cmd LOAD appends a reference point to
// the store, QUERY finds the least squared distance from the point to every
// stored point, capped at distance_cap squared, and keeps the largest such
// minimum; REPORT returns on rsp the square root of that maximum, the query
// count and the sticky overflow flag, then clears maximum and count; CLEAR
// empties the store and all running values. distance_cap is written over APB
// at address 0 (pready is always high).
// LOAD and CLEAR leave the unit idle. A QUERY with stored points scans
// them: the scan reads one entry of the reference RAM per cycle into a
// three-stage distance pipeline; with an empty store it skips the scan.
// A REPORT runs the bit-serial square root before the result register.
// Only one request is worked on at a time; requests are taken while a
// result still sits in the output register. If rsp is stalled, a second
// report waits for the register to free before new requests are taken.
// Reset clears the point count, maximum, count, flag and any pending result
// and sets distance_cap to 100.0; the RAM contents are not cleared.
module directed_hausdorff_distance_unit #(
	parameter int MAX_REF_POINTS = dhd_pkg::MAX_REF_POINTS_DEF,
	parameter int COORD_BITS     = dhd_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dhd_req_if.sink                       req,
	dhd_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dhd_pkg::APB_AW-1:0]    paddr,
	input  logic [dhd_pkg::APB_DW-1:0]    pwdata,
	output logic [dhd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int CB = COORD_BITS;
	localparam int AW = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1;
	localparam int CW = $clog2(MAX_REF_POINTS + 1);
	localparam int SQ_W  = dhd_pkg::SQ_W;
	localparam int CAP_W = dhd_pkg::CAP_W;
	localparam int CNT_W = dhd_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ROOT,
		ST_RESP
	} state_t;

	state_t                  state_q;
	logic [CAP_W-1:0]        cap_q;
	logic [CW-1:0]           ref_count_q;
	logic [AW-1:0]           idx_q;
	logic [SQ_W-1:0]         best_q, max_q;
	logic [CNT_W-1:0]        queries_q, cnt_hold_q;
	logic                    ovf_q, ovf_hold_q;
	logic [CB-1:0]           qx_q, qy_q, qz_q;
	logic                    rsp_valid_q;
	logic [CAP_W-1:0]        rsp_dist_q;
	logic [CNT_W-1:0]        rsp_cnt_q;
	logic                    rsp_ovf_q;

	logic                    req_acc;
	dhd_pkg::cmd_t           cmd;
	logic                    store_full;
	logic                    mem_wr;
	logic                    mem_rd;
	logic [3*CB-1:0]         wr_word, rd_word;
	logic                    scan_last;
	logic [2*CAP_W-1:0]      cap_sq;
	dhd_pkg::pipe_stat_t     pstat;
	logic [SQ_W-1:0]         sq_dist;
	logic                    root_start, root_busy;
	logic [dhd_pkg::ROOT_W-1:0] root;
	logic                    out_free;
	logic                    cfg_wr;

	// Handshake decode
	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid & req.ready;
	assign cmd        = dhd_pkg::cmd_t'(req.cmd);
	assign store_full = (ref_count_q == CW'(MAX_REF_POINTS));
	assign mem_wr     = req_acc && (cmd == dhd_pkg::CMD_LOAD) && !store_full;
	assign wr_word    = {req.point_z[CB-1:0], req.point_y[CB-1:0], req.point_x[CB-1:0]};
	assign mem_rd     = (state_q == ST_SCAN);
	assign scan_last  = ((CW'(idx_q) + CW'(1)) == ref_count_q);
	assign cap_sq     = (2*CAP_W)'(cap_q) * (2*CAP_W)'(cap_q);
	assign root_start = req_acc && (cmd == dhd_pkg::CMD_REPORT);
	assign out_free   = !rsp_valid_q || rsp.ready;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == dhd_pkg::REG_DISTANCE_CAP) ?
		dhd_pkg::APB_DW'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dhd_pkg::CAP_RESET;
		end else if (cfg_wr && (paddr[2] == dhd_pkg::REG_DISTANCE_CAP)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	dhd_ref_mem #(
		.DEPTH  (MAX_REF_POINTS),
		.AW     (AW),
		.WORD_W (3 * CB)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (ref_count_q[AW-1:0]),
		.wr_data (wr_word),
		.rd_en   (mem_rd),
		.rd_addr (idx_q),
		.rd_data (rd_word)
	);

	dhd_dist_pipe #(
		.COORD_BITS (CB)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (mem_rd),
		.ref_word (rd_word),
		.query_x  (qx_q),
		.query_y  (qy_q),
		.query_z  (qz_q),
		.stat     (pstat),
		.sq_dist  (sq_dist)
	);

	dhd_isqrt u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (max_q),
		.busy    (root_busy),
		.root    (root)
	);

	// Query point and running minimum
	always_ff @(posedge clk) begin
		if (req_acc && (cmd == dhd_pkg::CMD_QUERY)) begin
			qx_q   <= req.point_x[CB-1:0];
			qy_q   <= req.point_y[CB-1:0];
			qz_q   <= req.point_z[CB-1:0];
			best_q <= SQ_W'(cap_sq);
		end else if (pstat.dist_valid && (sq_dist < best_q)) begin
			best_q <= sq_dist;
		end
	end

	// Report snapshot taken as the report is accepted
	always_ff @(posedge clk) begin
		if (root_start) begin
			cnt_hold_q <= queries_q;
			ovf_hold_q <= ovf_q;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			rsp_dist_q <= root[CAP_W-1:0];
			rsp_cnt_q  <= cnt_hold_q;
			rsp_ovf_q  <= ovf_hold_q;
		end
	end

	// Controller: state, store count, running values, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_count_q <= '0;
			idx_q       <= '0;
			max_q       <= '0;
			queries_q   <= '0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (cmd)
							dhd_pkg::CMD_LOAD: begin
								if (store_full) begin
									ovf_q <= 1'b1;
								end else begin
									ref_count_q <= ref_count_q + CW'(1);
								end
							end
							dhd_pkg::CMD_QUERY: begin
								idx_q   <= '0;
								state_q <= (ref_count_q == '0) ? ST_DRAIN : ST_SCAN;
							end
							dhd_pkg::CMD_REPORT: begin
								max_q     <= '0;
								queries_q <= '0;
								state_q   <= ST_ROOT;
							end
							dhd_pkg::CMD_CLEAR: begin
								ref_count_q <= '0;
								max_q       <= '0;
								queries_q   <= '0;
								ovf_q       <= 1'b0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + AW'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last distance compared once the pipeline is empty
					if (!pstat.busy) begin
						if (best_q > max_q) begin
							max_q <= best_q;
						end
						if (queries_q != dhd_pkg::CNT_MAX) begin
							queries_q <= queries_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT: begin
					if (!root_busy) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.hausdorff_distance = rsp_dist_q;
	assign rsp.query_count        = rsp_cnt_q;
	assign rsp.store_overflowed   = rsp_ovf_q;

endmodule

// ----- rtl/core/dhd_checker.sv -----
// Port-level checks on the distance unit
module dhd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [dhd_pkg::CMD_W-1:0]   req_cmd,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [dhd_pkg::CAP_W-1:0]   rsp_dist,
	input logic [dhd_pkg::CNT_W-1:0]   rsp_cnt,
	input logic                        rsp_ovf,
	input logic                        pready,
	input logic [dhd_pkg::APB_DW-1:0]  prdata
);

	// A stalled result keeps its valid and payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dist)
			&& $stable(rsp_cnt) && $stable(rsp_ovf))
		else $error("stalled result changed");

	// A report keeps the unit busy while the root is worked out
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == dhd_pkg::CMD_REPORT) |=> !req_ready)
		else $error("request taken during report");

	// Load and clear leave the request channel ready
	a_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && ((req_cmd == dhd_pkg::CMD_LOAD)
			|| (req_cmd == dhd_pkg::CMD_CLEAR)) |=> req_ready)
		else $error("load or clear stalled the request channel");

	// Register reads stay within the cap width and never wait
	a_apb: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[dhd_pkg::APB_DW-1:dhd_pkg::CAP_W] == '0))
		else $error("bad APB read or wait state");

endmodule

bind directed_hausdorff_distance_unit dhd_checker u_dhd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_cmd   (req.cmd),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_dist  (rsp.hausdorff_distance),
	.rsp_cnt   (rsp.query_count),
	.rsp_ovf   (rsp.store_overflowed),
	.pready    (pready),
	.prdata    (prdata)
);
